/* rtl/prt_pkg.sv */
// Shared types and constants for the page reference-count range table.
// Holds field widths, request and status codes, and the shared unit's
// operation codes and request/response structs. No dependencies.
package prt_pkg;

   localparam int ADDR_W      = 64;
   localparam int LEN_W       = 32;
   localparam int SIZE_W      = 25;
   localparam int DONE_W      = 13;
   localparam int ENTRY_W     = 64;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   // request kinds
   localparam logic [1:0] TYPE_GET   = 2'd0;
   localparam logic [1:0] TYPE_PUT   = 2'd1;
   localparam logic [1:0] TYPE_CHECK = 2'd2;
   localparam logic [1:0] TYPE_WRITE = 2'd3;

   // result status
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;
   localparam logic [1:0] STATUS_BUSY   = 2'd3;

   // register byte-address select bit (registers sit 8 bytes apart)
   localparam int CSR_SEL_BIT = 3;

   // entry layout: present bit at bit 0, count moves in steps of two
   localparam logic [ENTRY_W-1:0] ENTRY_STEP   = 64'd2;
   localparam logic [ENTRY_W-1:0] RECLAIM_MARK = 64'hFFFF_FFFF_FFFF_FFFE;

   // shared unit operations
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic               op;
      logic [ENTRY_W-1:0] a;
      logic [ENTRY_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ENTRY_W:0] res;   // bit 64 is carry out on add, borrow on subtract
      logic             zero;  // low 64 bits of the result are zero
   } alu_rsp_type;

endpackage

/* rtl/page_refcount_range_table.sv */
// Top level of the page reference-count range table: sequencer, registers.
// Depends on prt_pkg, prt_alu (shared add/subtract unit) and prt_ram.
//
// Usage:
//   req channel: one request per transfer. tuser carries the request kind
//   (get, put, check, write present bit); tdata carries address, length and
//   the present flag. rsp channel: one result per request with status and
//   the number of pages visited. The csr port holds the region base address
//   and region size.
//   A request first runs five setup steps on the shared adder (range end,
//   region limit, two bound compares, page count), then visits pages in
//   ascending order with a read and a read-modify-write per page, as
//   set by the single table memory port and the shared adder. A get scans
//   the pages for the reclaim marker first and then updates them, so it
//   takes two passes. req_tready is high only while no request is in work.
//   Reset starts a clearing pass that zeroes the table, one entry a cycle,
//   with req_tready low; csr writes are taken as ever. If the receiver
//   stalls, the result waits in the output register; the next request is
//   accepted and worked on, and its result waits until the output register
//   is free.
module page_refcount_range_table #(
   parameter int TABLE_ENTRIES               = 4096,
   parameter int PAGE_BITS                   = 12,
   parameter int ENTRIES_PER_TABLE_PAGE_BITS = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: addr[63:0], length[95:64], present_flag[96], zero pad [103:97]
   input  logic [prt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]                          req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: status[1:0], pages_done[14:2], zero pad [15]
   output logic [prt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [prt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [prt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import prt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int PG_W  = ADDR_W + 1 - PAGE_BITS;     // page number of an exact sum
   localparam int SP_W  = ADDR_W - PAGE_BITS;         // page number of an address
   localparam int CNT_W = SIZE_W + 1 - PAGE_BITS;     // pages inside the region
   localparam logic [IDX_W-1:0] OFF_MASK =
      IDX_W'((64'd1 << ENTRIES_PER_TABLE_PAGE_BITS) - 64'd1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_END   = 4'd2;
   localparam logic [3:0] S_LIM   = 4'd3;
   localparam logic [3:0] S_LO    = 4'd4;
   localparam logic [3:0] S_HI    = 4'd5;
   localparam logic [3:0] S_CNT   = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_MOD   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          type_ff, type_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                flag_ff, flag_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ADDR_W:0]     end_sum_ff, end_sum_in;
   logic [PG_W-1:0]     end_pg_ff, end_pg_in;
   logic [PG_W-1:0]     lim_pg_ff, lim_pg_in;
   logic                lo_fail_ff, lo_fail_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [CNT_W-1:0]    cnt0_ff, cnt0_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    idx0_ff, idx0_in;
   logic [DONE_W-1:0]   done_ff, done_in;
   logic [1:0]          status_ff, status_in;
   logic                update_ff, update_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [DONE_W-1:0]   rsp_done_ff, rsp_done_in;

   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;

   logic                ram_wen;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic                ram_ren;
   logic [ENTRY_W-1:0]  ram_rdata;

   logic                csr_write;
   logic [SP_W-1:0]     start_pg;
   logic [IDX_W-1:0]    base_pg;
   logic [IDX_W-1:0]    idx_start;

   prt_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   prt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (idx_ff),
      .wdata (ram_wdata),
      .ren   (ram_ren),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign start_pg  = addr_ff[ADDR_W-1:PAGE_BITS];
   assign base_pg   = base_ff[PAGE_BITS+IDX_W-1:PAGE_BITS];
   assign idx_start = (base_pg[IDX_W-1:0] & OFF_MASK) + start_pg[IDX_W-1:0]
                      - base_pg[IDX_W-1:0];

   // shared unit operand selection
   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;
      case (state_ff)
         S_END: begin
            alu_req.a = addr_ff;
            alu_req.b = {{(ENTRY_W-LEN_W){1'b0}}, len_ff};
         end
         S_LIM: begin
            alu_req.a = base_ff;
            alu_req.b = {{(ENTRY_W-SIZE_W){1'b0}}, size_ff};
         end
         S_LO: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {start_pg, {PAGE_BITS{1'b0}}};
            alu_req.b  = base_ff;
         end
         S_HI: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {{(ENTRY_W-PG_W){1'b0}}, lim_pg_ff};
            alu_req.b  = {{(ENTRY_W-PG_W){1'b0}}, end_pg_ff};
         end
         S_CNT: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {{(ENTRY_W-PG_W){1'b0}}, end_pg_ff};
            alu_req.b  = {{(ENTRY_W-SP_W){1'b0}}, start_pg};
         end
         S_MOD: begin
            alu_req.a = ram_rdata;
            alu_req.b = ENTRY_STEP;
            if (type_ff == TYPE_PUT) begin
               alu_req.b = RECLAIM_MARK;   // adding all ones but bit 0 takes two off
            end else if (type_ff == TYPE_GET && !update_ff) begin
               alu_req.op = ALU_SUB;
               alu_req.b  = RECLAIM_MARK;
            end
         end
         default: begin
            alu_req.op = ALU_ADD;
         end
      endcase
   end

   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      flag_in       = flag_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      end_sum_in    = end_sum_ff;
      end_pg_in     = end_pg_ff;
      lim_pg_in     = lim_pg_ff;
      lo_fail_in    = lo_fail_ff;
      remain_in     = remain_ff;
      cnt0_in       = cnt0_ff;
      idx_in        = idx_ff;
      idx0_in       = idx0_ff;
      done_in       = done_ff;
      status_in     = status_ff;
      update_in     = update_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      ram_wen       = 1'b0;
      ram_wdata     = '0;
      ram_ren       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         if (csr_paddr[CSR_SEL_BIT]) begin
            size_in = csr_pwdata[SIZE_W-1:0];
         end else begin
            base_in = csr_pwdata;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            ram_wen = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               addr_in  = req_tdata[ADDR_W-1:0];
               len_in   = req_tdata[ADDR_W+LEN_W-1:ADDR_W];
               flag_in  = req_tdata[ADDR_W+LEN_W];
               state_in = S_END;
            end
         end
         S_END: begin
            end_sum_in = alu_rsp.res;
            state_in   = S_LIM;
         end
         S_LIM: begin
            // round the range end up to a page bound
            end_pg_in = end_sum_ff[ADDR_W:PAGE_BITS]
                        + PG_W'(|end_sum_ff[PAGE_BITS-1:0]);
            lim_pg_in = alu_rsp.res[ADDR_W:PAGE_BITS];
            state_in  = S_LO;
         end
         S_LO: begin
            lo_fail_in = alu_rsp.res[ENTRY_W];
            state_in   = S_HI;
         end
         S_HI: begin
            if (lo_fail_ff || alu_rsp.res[ENTRY_W]) begin
               status_in = STATUS_RANGE;
               done_in   = '0;
               state_in  = S_DONE;
            end else begin
               state_in = S_CNT;
            end
         end
         S_CNT: begin
            remain_in = alu_rsp.res[CNT_W-1:0];
            cnt0_in   = alu_rsp.res[CNT_W-1:0];
            idx_in    = idx_start;
            idx0_in   = idx_start;
            done_in   = '0;
            status_in = STATUS_OK;
            update_in = 1'b0;
            state_in  = S_RD;
         end
         S_RD: begin
            if (remain_ff == '0) begin
               if (type_ff == TYPE_GET && !update_ff) begin
                  // scan found no reclaim marker: rewind for the update pass
                  update_in = 1'b1;
                  remain_in = cnt0_ff;
                  idx_in    = idx0_ff;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               ram_ren  = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            idx_in    = idx_ff + 1'b1;
            remain_in = remain_ff - 1'b1;
            state_in  = S_RD;
            case (type_ff)
               TYPE_GET: begin
                  if (update_ff) begin
                     ram_wen   = 1'b1;
                     ram_wdata = alu_rsp.res[ENTRY_W-1:0];
                  end else if (alu_rsp.zero) begin
                     status_in = STATUS_BUSY;
                     state_in  = S_DONE;
                  end else begin
                     done_in = done_ff + 1'b1;
                  end
               end
               TYPE_PUT: begin
                  ram_wen   = 1'b1;
                  ram_wdata = alu_rsp.res[ENTRY_W-1:0];
                  done_in   = done_ff + 1'b1;
               end
               TYPE_CHECK: begin
                  if (!ram_rdata[0]) begin
                     status_in = STATUS_ABSENT;
                     state_in  = S_DONE;
                  end else begin
                     done_in = done_ff + 1'b1;
                  end
               end
               default: begin
                  ram_wen   = 1'b1;
                  ram_wdata = {ram_rdata[ENTRY_W-1:1], flag_ff};
                  done_in   = done_ff + 1'b1;
               end
            endcase
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_done_in   = done_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         size_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
      end
      type_ff       <= type_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      flag_ff       <= flag_in;
      end_sum_ff    <= end_sum_in;
      end_pg_ff     <= end_pg_in;
      lim_pg_ff     <= lim_pg_in;
      lo_fail_ff    <= lo_fail_in;
      remain_ff     <= remain_in;
      cnt0_ff       <= cnt0_in;
      idx0_ff       <= idx0_in;
      done_ff       <= done_in;
      status_ff     <= status_in;
      update_ff     <= update_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_done_ff, rsp_status_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[CSR_SEL_BIT] ? {{(CSR_DATA_W-SIZE_W){1'b0}}, size_ff}
                                              : base_ff;

endmodule

/* rtl/prt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Width and depth set by parameters; no package dependency.
module prt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     ren,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/prt_alu.sv */
// Shared 64-bit add/subtract unit with carry/borrow and zero flag.
// Uses prt_pkg for the request/response structs and operation codes.
module prt_alu (
   input  prt_pkg::alu_req_type req,
   output prt_pkg::alu_rsp_type rsp
);
   import prt_pkg::*;

   logic [ENTRY_W:0] res;

   always_comb begin
      case (req.op)
         ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
         default: res = '0;
      endcase
   end

   assign rsp.res  = res;
   assign rsp.zero = (res[ENTRY_W-1:0] == '0);

endmodule

/* rtl/prt_checker.sv */
// Port-level checks for the page reference-count range table, with bind.
// Depends on prt_pkg for widths and status codes.
module prt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [prt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import prt_pkg::*;

   // reset starts the clearing pass, so no request is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready right after reset");

   // one request at a time: an accepted transfer drops ready
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready stayed high after an accepted request");

   // a rejected range visits no page
   a_range_no_pages: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == STATUS_RANGE) |-> (rsp_tdata[14:2] == '0))
      else $error("out of range result with pages visited");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind page_refcount_range_table prt_checker u_prt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/page_refcount_range_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for page_refcount_range_table: directed and random
// range requests on the req stream, results checked against a local model.
// Depends on prt_pkg and the page_refcount_range_table RTL.
module page_refcount_range_table_tb;
   import prt_pkg::*;

   localparam int PAGE_SH     = 12;
   localparam int OFF_BITS    = 9;
   localparam int SLOTS       = 4096;
   localparam int IDX_W       = 12;
   localparam int PG_W        = 53;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_MASK   = PAGE_BYTES - 1;
   localparam int REG_BASE    = 0;
   localparam int REG_SIZE    = 1;
   localparam int DRAIN_WAIT  = 40;
   localparam int QUIET_LIMIT = 100000;
   localparam int HOLD_CYCLES = 1500;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 220;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = 25'h100_0000;
   localparam logic [PG_W-1:0]   ADDR_PAGES = 53'h10_0000_0000_0000;

   typedef struct packed {
      logic [1:0]        status;
      logic [DONE_W-1:0] pages;
   } page_result_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [1:0]             req_tuser   = TYPE_GET;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // local copy of the table and the region registers
   logic [ENTRY_W-1:0] page_tbl [SLOTS] = '{default: '0};
   logic [ADDR_W-1:0]  base_reg = '0;
   logic [SIZE_W-1:0]  size_reg = '0;

   page_result_type pending_results [$];
   int unsigned  mismatch_count = 0;
   int unsigned  requests_sent  = 0;
   int unsigned  regions_set    = 0;
   int unsigned  range_seen     = 0;
   int unsigned  absent_seen    = 0;
   int unsigned  busy_seen      = 0;
   int unsigned  quiet_cycles   = 0;
   int unsigned  hold_ask       = 0;
   int unsigned  hold_left      = 0;
   int unsigned  stall_left     = 0;
   bit           steady         = 1'b0;

   page_refcount_range_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   function automatic logic [PG_W-1:0] region_limit_page();
      logic [ADDR_W:0] sum;
      sum = {1'b0, base_reg} + (ADDR_W+1)'(size_reg);
      return sum[ADDR_W:PAGE_SH];
   endfunction

   function automatic logic [PG_W-1:0] first_page();
      return PG_W'(base_reg[ADDR_W-1:PAGE_SH]) + PG_W'(base_reg[PAGE_SH-1:0] != '0);
   endfunction

   function automatic logic [IDX_W-1:0] entry_slot(logic [PG_W-1:0] pg,
                                                   logic [PG_W-1:0] base_pg);
      return IDX_W'(pg - base_pg) + IDX_W'(base_pg[OFF_BITS-1:0]);
   endfunction

   // Work out the result of one request and update the local table.
   function automatic page_result_type apply_page_request(logic [1:0] kind,
         logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len, logic flag);
      logic [ADDR_W:0]    end_sum;
      logic [PG_W-1:0]    start_pg, end_pg, base_pg, pg;
      logic [ADDR_W-1:0]  start;
      logic [IDX_W-1:0]   idx;
      page_result_type    res;
      int unsigned        done;
      bit                 busy;
      end_sum  = {1'b0, addr} + (ADDR_W+1)'(len);
      start    = {addr[ADDR_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
      start_pg = PG_W'(addr[ADDR_W-1:PAGE_SH]);
      end_pg   = end_sum[ADDR_W:PAGE_SH];
      if (end_sum[PAGE_SH-1:0] != '0) end_pg++;
      base_pg  = PG_W'(base_reg[ADDR_W-1:PAGE_SH]);
      res.status = STATUS_OK;
      res.pages  = '0;
      done = 0;
      busy = 1'b0;
      if (start < base_reg || end_pg > region_limit_page()) begin
         res.status = STATUS_RANGE;
         return res;
      end
      if (kind == TYPE_GET) begin
         // scan for the reclaim marker before touching anything
         for (pg = start_pg; pg < end_pg; pg++) begin
            if (page_tbl[entry_slot(pg, base_pg)] == RECLAIM_MARK) begin
               busy = 1'b1;
               break;
            end
            done++;
         end
         if (busy) begin
            res.status = STATUS_BUSY;
         end else begin
            for (pg = start_pg; pg < end_pg; pg++) begin
               idx = entry_slot(pg, base_pg);
               page_tbl[idx] = page_tbl[idx] + ENTRY_STEP;
            end
         end
      end else begin
         for (pg = start_pg; pg < end_pg; pg++) begin
            idx = entry_slot(pg, base_pg);
            if (kind == TYPE_PUT) begin
               page_tbl[idx] = page_tbl[idx] - ENTRY_STEP;
            end else if (kind == TYPE_CHECK) begin
               if (!page_tbl[idx][0]) begin
                  res.status = STATUS_ABSENT;
                  break;
               end
            end else begin
               page_tbl[idx][0] = flag;
            end
            done++;
         end
      end
      res.pages = DONE_W'(done);
      return res;
   endfunction

   // ------------------------------------------------------------- helpers
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 50)
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic send_req(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len, input logic flag);
      int unsigned gap;
      page_result_type want;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'b0, flag, len, addr};
      do @(posedge clock); while (!req_tready);
      want = apply_page_request(kind, addr, len, flag);
      pending_results.push_back(want);
      requests_sent++;
      case (want.status)
         STATUS_RANGE:  range_seen++;
         STATUS_ABSENT: absent_seen++;
         STATUS_BUSY:   busy_seen++;
         default: ;
      endcase
   endtask

   function automatic logic [ADDR_W-1:0] page_addr(int unsigned k);
      return 64'(first_page() + PG_W'(k)) << PAGE_SH;
   endfunction

   task automatic send_pages(input logic [1:0] kind, input int unsigned first,
                             input int unsigned n, input logic flag);
      send_req(kind, page_addr(first), LEN_W'(n * PAGE_BYTES), flag);
   endtask

   // Mostly well-formed ranges inside the region, some straddling an edge,
   // some anywhere in the address space.
   task automatic send_mixed();
      logic [1:0]        kind;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [PG_W-1:0]   fp, top, npg, page;
      int unsigned       r, cnt, room, lo, trim;
      r = $urandom_range(0, 99);
      if (r < 35)      kind = TYPE_GET;
      else if (r < 55) kind = TYPE_PUT;
      else if (r < 80) kind = TYPE_CHECK;
      else             kind = TYPE_WRITE;
      fp  = first_page();
      top = region_limit_page();
      if (top > ADDR_PAGES) top = ADDR_PAGES;
      npg = (top > fp) ? top - fp : '0;
      r = $urandom_range(0, 99);
      if (npg == 0 || r < 10) begin
         addr = {$urandom, $urandom};
         len  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000);
      end else if (r < 16) begin
         if (fp != 0 && $urandom_range(0, 1)) begin
            addr = (64'(fp - 1) << PAGE_SH) | 64'($urandom_range(0, PAGE_MASK));
            len  = $urandom_range(PAGE_BYTES, 4 * PAGE_BYTES);
         end else begin
            addr = (64'(top - 1) << PAGE_SH) | 64'($urandom_range(0, PAGE_MASK));
            len  = $urandom_range(PAGE_BYTES + 1, 4 * PAGE_BYTES);
         end
      end else begin
         room = int'(npg);
         page = fp + PG_W'($urandom_range(0, room - 1));
         room = int'(fp + npg - page);
         r = $urandom_range(0, 99);
         if (r < 8)       cnt = 0;
         else if (r < 75) cnt = $urandom_range(1, 4);
         else if (r < 97) cnt = $urandom_range(5, 32);
         else             cnt = $urandom_range(33, 256);
         if (cnt > room) cnt = room;
         addr = 64'(page) << PAGE_SH;
         len  = '0;
         if (cnt != 0) begin
            lo   = $urandom_range(0, 1) ? 0 : $urandom_range(0, PAGE_MASK);
            trim = $urandom_range(0, 1) ? 0 :
                   $urandom_range(0, PAGE_MASK - ((cnt == 1) ? lo : 0));
            addr = addr | 64'(lo);
            len  = LEN_W'(cnt * PAGE_BYTES - lo - trim);
         end
      end
      send_req(kind, addr, len, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input int idx, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(idx << CSR_SEL_BIT);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_regs();
      logic [63:0] rd;
      csr_access(1'b0, REG_BASE, '0, rd);
      if (rd !== base_reg) report_mismatch("region base readback", rd, base_reg);
      csr_access(1'b0, REG_SIZE, '0, rd);
      if (rd !== 64'(size_reg)) report_mismatch("region size readback", rd, 64'(size_reg));
   endtask

   task automatic set_region(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size);
      logic [63:0] unused;
      csr_access(1'b1, REG_BASE, base, unused);
      csr_access(1'b1, REG_SIZE, 64'(size), unused);
      base_reg = base;
      size_reg = size;
      regions_set++;
      check_regs();
   endtask

   // ------------------------------------------------------ result checking
   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(rsp_tdata), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status", 64'(rsp_tdata[1:0]), 64'(want.status));
            if (rsp_tdata[2 +: DONE_W] !== want.pages)
               report_mismatch("pages_done", 64'(rsp_tdata[2 +: DONE_W]), 64'(want.pages));
         end
      end
   end

   // receiver: random stalls after each transfer, plus a long hold on request
   always @(posedge clock) begin
      if (hold_ask != 0) begin
         hold_left = hold_ask;
         hold_ask  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reset_state();
      // the region is empty after reset: only an empty aligned range passes
      send_req(TYPE_GET, 64'h0, 32'h0, 1'b0);
      send_req(TYPE_CHECK, 64'h5, 32'h0, 1'b0);
      wait_drained();
      check_regs();
   endtask

   task automatic test_directed_ops();
      set_region(64'h0000_0000_004A_0800, 25'(64 * PAGE_BYTES + 'h800));
      send_pages(TYPE_GET, 0, 0, 1'b0);
      send_pages(TYPE_CHECK, 0, 1, 1'b0);
      send_pages(TYPE_WRITE, 0, 4, 1'b1);
      send_pages(TYPE_CHECK, 0, 6, 1'b0);
      send_req(TYPE_CHECK, page_addr(1) + 64'h123, 32'h2000, 1'b0);
      send_pages(TYPE_GET, 0, 4, 1'b0);
      // a put on a fresh page leaves the reclaim marker
      send_pages(TYPE_PUT, 8, 1, 1'b0);
      send_pages(TYPE_GET, 6, 4, 1'b0);
      send_pages(TYPE_PUT, 0, 4, 1'b0);
      send_pages(TYPE_WRITE, 2, 1, 1'b0);
      send_pages(TYPE_CHECK, 0, 4, 1'b0);
      // start rounds down below an unaligned base
      send_req(TYPE_GET, base_reg, 32'h1000, 1'b0);
      send_req(TYPE_PUT, 64'h0, 32'h1000, 1'b0);
      send_pages(TYPE_CHECK, 63, 2, 1'b0);
      send_pages(TYPE_WRITE, 63, 1, 1'b1);
      send_pages(TYPE_GET, 0, 64, 1'b0);
      send_pages(TYPE_PUT, 8, 1, 1'b0);
      send_pages(TYPE_GET, 0, 64, 1'b0);
      send_req(TYPE_CHECK, page_addr(0), 32'hFFFF_FFFF, 1'b0);
      send_req(TYPE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1);
      send_req(TYPE_WRITE, page_addr(5) + 64'h1, 32'h0, 1'b1);
      send_req(TYPE_GET, page_addr(3), 32'h0, 1'b0);
      // count wraps below zero, then a get walks it back onto the marker
      send_pages(TYPE_PUT, 20, 2, 1'b0);
      send_pages(TYPE_PUT, 20, 2, 1'b0);
      send_pages(TYPE_GET, 20, 2, 1'b0);
      send_pages(TYPE_GET, 20, 1, 1'b0);
      wait_drained();
   endtask

   task automatic test_table_wrap();
      // table-page offset 511 with a full region: indexes wrap past the end
      set_region(64'h0000_0012_341F_F000, SIZE_MAX);
      send_pages(TYPE_WRITE, 3580, 12, 1'b1);
      send_pages(TYPE_CHECK, 3580, 14, 1'b0);
      send_pages(TYPE_GET, 0, 4096, 1'b0);
      send_pages(TYPE_WRITE, 0, 4096, 1'b1);
      send_pages(TYPE_CHECK, 0, 4096, 1'b0);
      send_pages(TYPE_PUT, 4095, 1, 1'b0);
      send_pages(TYPE_GET, 4090, 6, 1'b0);
      wait_drained();
   endtask

   task automatic test_top_of_space();
      // region end lies past 2^64; ranges may run off the address space
      set_region(64'hFFFF_FFFF_FFC0_0000, SIZE_MAX);
      send_req(TYPE_WRITE, 64'hFFFF_FFFF_FFFF_F000, 32'h1000, 1'b1);
      send_req(TYPE_CHECK, 64'hFFFF_FFFF_FFFF_F000, 32'h2000, 1'b0);
      send_req(TYPE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_req(TYPE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 1'b0);
      repeat (40) send_mixed();
      wait_drained();
   endtask

   task automatic test_random_regions();
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      for (int p = 0; p < RAND_PHASES; p++) begin
         base = {$urandom, $urandom};
         if ($urandom_range(0, 1)) base[PAGE_SH-1:0] = '0;
         if (p == 0)      size = SIZE_MAX;
         else if (p == 1) size = 25'(2 * PAGE_BYTES + 'h123);
         else             size = 25'($urandom_range(4 * PAGE_BYTES, 48 * PAGE_BYTES));
         set_region(base, size);
         steady = (p == 3);
         repeat (PHASE_ITEMS) send_mixed();
         wait_drained();
         steady = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      set_region(64'h0000_0000_8000_0000, 25'(16 * PAGE_BYTES));
      steady   = 1'b1;
      hold_ask = HOLD_CYCLES;
      repeat (40) send_mixed();
      wait_drained();
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_ops();
      test_table_wrap();
      test_top_of_space();
      test_random_regions();
      test_backpressure();
      wait_drained();
      $display("Ran %0d requests, %0d region settings, %0d out of range, %0d absent, %0d busy.",
               requests_sent, regions_set, range_seen, absent_seen, busy_seen);
      $display("Covered index wrap, full-region walks, top-of-space ranges, a long stall.");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
